>>> rtl/core/dmsh_pkg.sv
package dmsh_pkg;

    localparam int DUTY_W    = 16;
    localparam int STEP_W    = 16;
    localparam int RATE_W    = 24;
    localparam int ELAPSED_W = 16;
    localparam int PROD_W    = RATE_W + ELAPSED_W;

    localparam logic signed [DUTY_W-1:0] DUTY_FULL  = 16'sd32767;
    localparam logic [RATE_W-1:0]        RATE_RESET = 24'd32767;
    localparam logic [STEP_W-1:0]        STEP_MAX   = 16'hFFFF;

    typedef logic signed [DUTY_W-1:0] t_duty;

    typedef struct packed {
        t_duty             target_left;
        t_duty             target_right;
        logic [STEP_W-1:0] step;
        logic              stop;
    } t_tick;

    typedef struct packed {
        t_duty applied_left;
        t_duty applied_right;
        logic  drive_enable;
    } t_drive;

    function automatic t_duty clamp_target(input t_duty target);
        return (target < -DUTY_FULL) ? -DUTY_FULL : target;
    endfunction

    // A duty that must reverse first heads to zero at twice the step.
    function automatic t_duty slew_duty(input t_duty duty, input t_duty target,
                                        input logic [STEP_W-1:0] step);
        logic               opposite;
        logic signed [17:0] goal;
        logic signed [17:0] cur;
        logic signed [17:0] stp;
        logic signed [17:0] diff;
        logic signed [17:0] span;
        logic signed [17:0] nxt;
        opposite = (target > 0 && duty < 0) || (target < 0 && duty > 0);
        cur  = 18'(duty);
        goal = opposite ? 18'sd0 : 18'(target);
        stp  = opposite ? $signed({1'b0, step, 1'b0}) : $signed({2'b00, step});
        diff = goal - cur;
        span = (diff < 0) ? -diff : diff;
        if (span <= stp) begin
            nxt = goal;
        end else if (goal > cur) begin
            nxt = cur + stp;
        end else begin
            nxt = cur - stp;
        end
        return t_duty'(nxt[DUTY_W-1:0]);
    endfunction

endpackage

>>> rtl/core/dmsh_if.sv
interface dmsh_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target_left;
    logic signed [15:0] target_right;
    logic [15:0]        elapsed;
    logic               stop_request;

    modport source (output valid, target_left, target_right, elapsed, stop_request,
                    input ready);
    modport sink (input valid, target_left, target_right, elapsed, stop_request,
                  output ready);
endinterface

interface dmsh_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] ramp_rate;

    modport source (output valid, ramp_rate, input ready);
    modport sink (input valid, ramp_rate, output ready);
endinterface

interface dmsh_out_if #(
    parameter int PWM_BITS = 10
);
    logic                valid;
    logic                ready;
    logic [PWM_BITS-1:0] left_forward_level;
    logic [PWM_BITS-1:0] left_reverse_level;
    logic [PWM_BITS-1:0] right_forward_level;
    logic [PWM_BITS-1:0] right_reverse_level;
    logic                drive_enable;
    logic signed [15:0]  applied_left;
    logic signed [15:0]  applied_right;

    modport source (output valid, left_forward_level, left_reverse_level,
                    right_forward_level, right_reverse_level, drive_enable,
                    applied_left, applied_right, input ready);
    modport sink (input valid, left_forward_level, left_reverse_level,
                  right_forward_level, right_reverse_level, drive_enable,
                  applied_left, applied_right, output ready);
endinterface

>>> rtl/core/dmsh_step.sv
module dmsh_step
    import dmsh_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    dmsh_cfg_if.sink     i_cfg,
    dmsh_in_if.sink      i_tick,
    output logic         o_valid,
    output t_tick        o_tick,
    input  logic         i_ready
);

    logic [RATE_W-1:0]        r_rate;
    logic                     r_valid;
    t_tick                    r_tick;
    t_tick                    n_tick;
    logic [PROD_W-1:0]        w_prod;
    logic [PROD_W-17:0]       w_scaled;

    assign i_cfg.ready  = 1'b1;
    assign i_tick.ready = !r_valid || i_ready;

    assign w_prod   = PROD_W'(r_rate) * PROD_W'(i_tick.elapsed);
    assign w_scaled = w_prod[PROD_W-1:16];

    always_comb begin
        n_tick.target_left  = clamp_target(i_tick.target_left);
        n_tick.target_right = clamp_target(i_tick.target_right);
        n_tick.step         = (|w_scaled[PROD_W-17:STEP_W]) ? STEP_MAX
                                                            : w_scaled[STEP_W-1:0];
        n_tick.stop         = i_tick.stop_request;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg.valid) begin
            r_rate <= i_cfg.ramp_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_tick <= n_tick;
        end
    end

    assign o_valid = r_valid;
    assign o_tick  = r_tick;

endmodule

>>> rtl/core/dmsh_slew.sv
module dmsh_slew
    import dmsh_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_tick  i_tick,
    output logic   o_ready,
    output logic   o_valid,
    output t_drive o_drive,
    input  logic   i_ready
);

    logic   r_valid;
    t_drive r_drive;
    t_drive n_drive;

    assign o_ready = !r_valid || i_ready;

    // The applied duties held in the result register are the motor state.
    always_comb begin
        if (i_tick.stop) begin
            n_drive = '0;
        end else begin
            n_drive.applied_left  = slew_duty(r_drive.applied_left, i_tick.target_left,
                                              i_tick.step);
            n_drive.applied_right = slew_duty(r_drive.applied_right, i_tick.target_right,
                                              i_tick.step);
            n_drive.drive_enable  = (n_drive.applied_left != 0)
                                 || (n_drive.applied_right != 0)
                                 || (i_tick.target_left != 0)
                                 || (i_tick.target_right != 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_drive <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (i_valid && o_ready) begin
                r_drive <= n_drive;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_drive = r_drive;

endmodule

>>> rtl/core/dmsh_level.sv
module dmsh_level
    import dmsh_pkg::*;
#(
    parameter int PWM_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_drive      i_drive,
    output logic        o_ready,
    dmsh_out_if.source  o_result
);

    localparam int LVL_PROD_W = 15 + PWM_BITS;

    logic                r_valid;
    logic [PWM_BITS-1:0] r_left_fwd;
    logic [PWM_BITS-1:0] r_left_rev;
    logic [PWM_BITS-1:0] r_right_fwd;
    logic [PWM_BITS-1:0] r_right_rev;
    logic                r_enable;
    t_duty               r_applied_left;
    t_duty               r_applied_right;
    logic [PWM_BITS-1:0] w_left_lvl;
    logic [PWM_BITS-1:0] w_right_lvl;

    // Magnitude times full PWM scale, divided by 32767 through a shift and
    // at most three correction steps on the remainder.
    function automatic logic [PWM_BITS-1:0] level_of(input t_duty duty);
        logic [14:0]           mag;
        logic [LVL_PROD_W-1:0] prod;
        logic [PWM_BITS-1:0]   q0;
        logic [16:0]           rem;
        logic [PWM_BITS:0]     q;
        mag  = (duty < 0) ? 15'(-duty) : 15'(duty);
        prod = {mag, {PWM_BITS{1'b0}}} - LVL_PROD_W'(mag);
        q0   = prod[LVL_PROD_W-1:15];
        rem  = 17'(prod[14:0]) + 17'(q0);
        if (rem >= 17'd98301) begin
            q = (PWM_BITS+1)'(q0) + (PWM_BITS+1)'(2'd3);
        end else if (rem >= 17'd65534) begin
            q = (PWM_BITS+1)'(q0) + (PWM_BITS+1)'(2'd2);
        end else if (rem >= 17'd32767) begin
            q = (PWM_BITS+1)'(q0) + (PWM_BITS+1)'(2'd1);
        end else begin
            q = (PWM_BITS+1)'(q0);
        end
        return q[PWM_BITS-1:0];
    endfunction

    assign w_left_lvl  = level_of(i_drive.applied_left);
    assign w_right_lvl = level_of(i_drive.applied_right);

    assign o_ready = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_left_fwd      <= (i_drive.applied_left > 0) ? w_left_lvl : '0;
            r_left_rev      <= (i_drive.applied_left < 0) ? w_left_lvl : '0;
            r_right_fwd     <= (i_drive.applied_right > 0) ? w_right_lvl : '0;
            r_right_rev     <= (i_drive.applied_right < 0) ? w_right_lvl : '0;
            r_enable        <= i_drive.drive_enable;
            r_applied_left  <= i_drive.applied_left;
            r_applied_right <= i_drive.applied_right;
        end
    end

    assign o_result.valid               = r_valid;
    assign o_result.left_forward_level  = r_left_fwd;
    assign o_result.left_reverse_level  = r_left_rev;
    assign o_result.right_forward_level = r_right_fwd;
    assign o_result.right_reverse_level = r_right_rev;
    assign o_result.drive_enable        = r_enable;
    assign o_result.applied_left        = r_applied_left;
    assign o_result.applied_right       = r_applied_right;

endmodule

>>> rtl/core/dual_motor_slew_limited_hbridge_drive_top.sv
// Slew-limited drive for two H-bridge motors.
// Each transfer on i_tick carries two signed Q1.15 duty targets, the time since
// the previous tick in units of 1/65536 second and a stop flag. Each transfer
// on o_result carries the four bridge PWM levels, the enable and both applied
// duties after the ramp step of that tick has been applied.
// A write on i_cfg sets the ramp rate; it is always ready and should only be
// used while no tick is in flight.
// A tick passes three registers: the input stage forms the ramp step with one
// multiplier, the slew stage updates the applied duties, and the level stage
// scales them to PWM levels. Its result is held in the level stage register,
// and one tick is taken every cycle at full rate, while o_result is ready.
// Reset clears the applied duties and the enable and restores the ramp rate to
// 32767. When the receiver stalls, results hold in the output register and
// ready falls stage by stage, so up to three ticks are taken before i_tick
// stops accepting.
module dual_motor_slew_limited_hbridge_drive_top
    import dmsh_pkg::*;
#(
    parameter int PWM_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmsh_cfg_if.sink    i_cfg,
    dmsh_in_if.sink     i_tick,
    dmsh_out_if.source  o_result
);

    logic   w_step_valid;
    t_tick  w_step_tick;
    logic   w_slew_ready;
    logic   w_slew_valid;
    t_drive w_slew_drive;
    logic   w_level_ready;

    dmsh_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_tick  (i_tick),
        .o_valid (w_step_valid),
        .o_tick  (w_step_tick),
        .i_ready (w_slew_ready)
    );

    dmsh_slew u_slew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_step_valid),
        .i_tick  (w_step_tick),
        .o_ready (w_slew_ready),
        .o_valid (w_slew_valid),
        .o_drive (w_slew_drive),
        .i_ready (w_level_ready)
    );

    dmsh_level #(
        .PWM_BITS (PWM_BITS)
    ) u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_slew_valid),
        .i_drive  (w_slew_drive),
        .o_ready  (w_level_ready),
        .o_result (o_result)
    );

endmodule

>>> rtl/core/dmsh_chk.sv
module dmsh_chk #(
    parameter int PWM_BITS = 10
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [PWM_BITS-1:0] i_left_fwd,
    input logic [PWM_BITS-1:0] i_left_rev,
    input logic [PWM_BITS-1:0] i_right_fwd,
    input logic [PWM_BITS-1:0] i_right_rev,
    input logic                i_enable,
    input logic signed [15:0]  i_applied_left,
    input logic signed [15:0]  i_applied_right
);

    a_left_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_applied_left >= 0 || i_left_fwd == '0)
                      && (i_applied_left <= 0 || i_left_rev == '0)))
        else $error("Left bridge drives the side opposite to its duty.");

    a_right_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_applied_right >= 0 || i_right_fwd == '0)
                      && (i_applied_right <= 0 || i_right_rev == '0)))
        else $error("Right bridge drives the side opposite to its duty.");

    a_disabled_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_enable) |->
            (i_applied_left == 0 && i_applied_right == 0))
        else $error("Drive is disabled while a duty is applied.");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("Result valid dropped before the transfer.");

endmodule

bind dual_motor_slew_limited_hbridge_drive_top dmsh_chk #(
    .PWM_BITS (PWM_BITS)
) u_dmsh_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_left_fwd      (o_result.left_forward_level),
    .i_left_rev      (o_result.left_reverse_level),
    .i_right_fwd     (o_result.right_forward_level),
    .i_right_rev     (o_result.right_reverse_level),
    .i_enable        (o_result.drive_enable),
    .i_applied_left  (o_result.applied_left),
    .i_applied_right (o_result.applied_right)
);

>>> bench/tb_dual_motor_slew_limited_hbridge_drive_top.sv
module tb_dual_motor_slew_limited_hbridge_drive_top;
    import dmsh_pkg::*;

    localparam int PWM_BITS     = 10;
    localparam int PIPE_LATENCY = 3;
    localparam int STALL_LIMIT  = 1000;
    localparam int FULL_SCALE   = DUTY_FULL;
    localparam int LEVEL_MAX    = (1 << PWM_BITS) - 1;
    localparam int STEP_CEIL    = STEP_MAX;

    typedef struct {
        logic [PWM_BITS-1:0] left_fwd;
        logic [PWM_BITS-1:0] left_rev;
        logic [PWM_BITS-1:0] right_fwd;
        logic [PWM_BITS-1:0] right_rev;
        logic                enable;
        t_duty               left_duty;
        t_duty               right_duty;
    } t_drive_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dmsh_in_if                          tick_if ();
    dmsh_cfg_if                         cfg_if ();
    dmsh_out_if #(.PWM_BITS(PWM_BITS))  result_if ();

    dual_motor_slew_limited_hbridge_drive_top #(
        .PWM_BITS(PWM_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_if),
        .i_tick   (tick_if),
        .o_result (result_if)
    );

    logic [RATE_W-1:0] model_rate;
    int                model_left;
    int                model_right;
    t_drive_result     pending_drive_q[$];
    t_drive_result     head_drive;

    int mismatch_count  = 0;
    int ticks_sent      = 0;
    int stop_ticks      = 0;
    int results_checked = 0;
    int rate_writes     = 0;
    int quiet_cycles    = 0;
    bit tx_idle_on      = 1'b1;
    bit rx_stalls_on    = 1'b1;
    bit hold_request    = 1'b0;
    int hold_len        = 120;

    always #5 i_clk = ~i_clk;

    function automatic int step_toward(int cur, int goal, int stp);
        int gap;
        gap = goal - cur;
        if (gap < 0) gap = -gap;
        if (gap <= stp) return goal;
        return (goal > cur) ? cur + stp : cur - stp;
    endfunction

    // A duty that has to reverse is first pulled to zero at twice the step.
    function automatic int ramp_duty(int duty, int target, int stp);
        if ((target > 0 && duty < 0) || (target < 0 && duty > 0)) begin
            return step_toward(duty, 0, 2 * stp);
        end
        return step_toward(duty, target, stp);
    endfunction

    function automatic logic [PWM_BITS-1:0] bridge_level(int duty);
        int mag;
        mag = (duty < 0) ? -duty : duty;
        return PWM_BITS'((mag * LEVEL_MAX) / FULL_SCALE);
    endfunction

    function automatic t_drive_result predict_drive(t_duty tl_raw, t_duty tr_raw,
                                                    logic [ELAPSED_W-1:0] el, logic stop);
        t_drive_result r;
        int            tl;
        int            tr;
        int            step;
        longint        prod;
        r = '{default: '0};
        if (stop) begin
            model_left  = 0;
            model_right = 0;
            return r;
        end
        tl   = (tl_raw < -FULL_SCALE) ? -FULL_SCALE : int'(tl_raw);
        tr   = (tr_raw < -FULL_SCALE) ? -FULL_SCALE : int'(tr_raw);
        prod = (longint'(model_rate) * longint'(el)) >> 16;
        step = (prod > STEP_CEIL) ? STEP_CEIL : int'(prod);
        model_left  = ramp_duty(model_left, tl, step);
        model_right = ramp_duty(model_right, tr, step);
        r.left_fwd   = (model_left > 0) ? bridge_level(model_left) : '0;
        r.left_rev   = (model_left < 0) ? bridge_level(model_left) : '0;
        r.right_fwd  = (model_right > 0) ? bridge_level(model_right) : '0;
        r.right_rev  = (model_right < 0) ? bridge_level(model_right) : '0;
        r.enable     = (model_left != 0) || (model_right != 0) || (tl != 0) || (tr != 0);
        r.left_duty  = t_duty'(model_left);
        r.right_duty = t_duty'(model_right);
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [32:0] want,
                               input logic signed [32:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            if (pending_drive_q.size() == 0) begin
                $error("Result transfer with no tick waiting for it");
                mismatch_count++;
            end else begin
                head_drive = pending_drive_q.pop_front();
                results_checked++;
                check_field("left_forward_level", head_drive.left_fwd,
                            result_if.left_forward_level);
                check_field("left_reverse_level", head_drive.left_rev,
                            result_if.left_reverse_level);
                check_field("right_forward_level", head_drive.right_fwd,
                            result_if.right_forward_level);
                check_field("right_reverse_level", head_drive.right_rev,
                            result_if.right_reverse_level);
                check_field("drive_enable", head_drive.enable, result_if.drive_enable);
                check_field("applied_left", head_drive.left_duty, result_if.applied_left);
                check_field("applied_right", head_drive.right_duty, result_if.applied_right);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((tick_if.valid & tick_if.ready) === 1'b1
                || (result_if.valid & result_if.ready) === 1'b1
                || (cfg_if.valid & cfg_if.ready) === 1'b1) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without a transfer", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                result_if.ready = 1'b0;
                repeat (hold_len - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
                result_if.ready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                result_if.ready = 1'b1;
            end
        end
    end

    task automatic send_tick(input t_duty tl, input t_duty tr,
                             input logic [ELAPSED_W-1:0] el, input logic stop);
        tick_if.target_left  = tl;
        tick_if.target_right = tr;
        tick_if.elapsed      = el;
        tick_if.stop_request = stop;
        tick_if.valid        = 1'b1;
        do @(posedge i_clk); while (tick_if.ready !== 1'b1);
        pending_drive_q.push_back(predict_drive(tl, tr, el, stop));
        ticks_sent++;
        if (stop) stop_ticks++;
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            tick_if.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        tick_if.valid = 1'b0;
        while (pending_drive_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] rate);
        cfg_if.ramp_rate = rate;
        cfg_if.valid     = 1'b1;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        model_rate = rate;
        rate_writes++;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic t_duty pick_target();
        case ($urandom_range(0, 7))
            0:       return t_duty'(FULL_SCALE);
            1:       return t_duty'(-FULL_SCALE - 1);
            2:       return t_duty'(-FULL_SCALE);
            3:       return '0;
            4:       return t_duty'(int'($urandom_range(0, 200)) - 100);
            default: return t_duty'($urandom);
        endcase
    endfunction

    // Runs hold their targets so that ramps play out over many ticks; noisy runs do not.
    task automatic send_segments(input int n_items);
        int                   left_n;
        int                   seg;
        int                   mode;
        bit                   noisy;
        t_duty                tl;
        t_duty                tr;
        logic [ELAPSED_W-1:0] el;
        left_n = n_items;
        while (left_n > 0) begin
            seg = $urandom_range(1, 20);
            if (seg > left_n) seg = left_n;
            tl    = pick_target();
            tr    = pick_target();
            mode  = $urandom_range(0, 4);
            noisy = ($urandom_range(0, 7) == 0);
            repeat (seg) begin
                if (noisy) begin
                    tl = t_duty'($urandom);
                    tr = t_duty'($urandom);
                end
                case (mode)
                    0:       el = ELAPSED_W'($urandom);
                    1:       el = ELAPSED_W'($urandom_range(0, 2000));
                    2:       el = ELAPSED_W'($urandom_range(0, 255));
                    3:       el = ELAPSED_W'($urandom_range(60000, 65535));
                    default: el = ELAPSED_W'($urandom_range(0, 12000));
                endcase
                send_tick(tl, tr, el, $urandom_range(0, 29) == 0);
            end
            left_n -= seg;
        end
    endtask

    task automatic test_reset_rate();
        send_tick(16'sd32767, -16'sd32768, 16'hFFFF, 1'b0);
        send_tick(16'sd32767, -16'sd32768, 16'hFFFF, 1'b0);
        send_tick(16'sd0, 16'sd0, 16'h0000, 1'b0);
        send_tick(16'sd100, -16'sd100, 16'h0000, 1'b1);
        send_tick(16'sd0, 16'sd0, 16'h0000, 1'b0);
    endtask

    task automatic test_directed_cases();
        wait_drained();
        write_rate('1);
        send_tick(16'sd32767, -16'sd32767, 16'hFFFF, 1'b0);
        send_tick(16'sd32767, -16'sd32767, 16'h0000, 1'b0);
        wait_drained();
        write_rate(RATE_RESET);
        repeat (4) send_tick(-16'sd32767, 16'sd32767, 16'd16384, 1'b0);
        repeat (2) send_tick(16'sd0, 16'sd0, 16'd16384, 1'b0);
        send_tick(16'sd1, -16'sd1, 16'd3, 1'b0);
        send_tick(-16'sd32768, 16'sd32767, 16'hFFFF, 1'b0);
        send_tick(16'sd32767, 16'sd32767, 16'd8192, 1'b0);
        send_tick(-16'sd5, 16'sd5, 16'd100, 1'b1);
        send_tick(16'sd0, 16'sd0, 16'hFFFF, 1'b0);
    endtask

    task automatic test_rate_sweep();
        logic [RATE_W-1:0] rates[7];
        rates = '{24'd0, 24'd1, 24'd2, 24'd65535, 24'd65536, 24'hFFFFFF, 24'd0};
        rates[6] = RATE_W'($urandom);
        foreach (rates[i]) begin
            wait_drained();
            write_rate(rates[i]);
            send_segments(30);
        end
    endtask

    task automatic test_stall_backlog();
        bit idle_saved;
        idle_saved   = tx_idle_on;
        tx_idle_on   = 1'b0;
        hold_len     = 120;
        hold_request = 1'b1;
        send_segments(30);
        tx_idle_on   = idle_saved;
    endtask

    task automatic test_pause_until_drained();
        send_segments(20);
        wait_drained();
        send_segments(20);
    endtask

    task automatic test_random_bulk();
        repeat (6) begin
            wait_drained();
            if ($urandom_range(0, 1) == 0) write_rate(RATE_W'($urandom));
            else write_rate(RATE_W'($urandom_range(0, 100000)));
            send_segments(210);
        end
    endtask

    task automatic test_full_rate();
        tx_idle_on   = 1'b0;
        rx_stalls_on = 1'b0;
        send_segments(150);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        tick_if.valid        = 1'b0;
        tick_if.target_left  = '0;
        tick_if.target_right = '0;
        tick_if.elapsed      = '0;
        tick_if.stop_request = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.ramp_rate     = '0;
        model_rate           = RATE_RESET;
        model_left           = 0;
        model_right          = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_rate();
        test_directed_cases();
        test_rate_sweep();
        test_stall_backlog();
        test_pause_until_drained();
        test_random_bulk();
        test_full_rate();

        tick_if.valid = 1'b0;
        wait_drained();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        $display("Run covered %0d ticks (%0d with stop) across %0d ramp rate settings,",
                 ticks_sent, stop_ticks, rate_writes);
        $display("with %0d drive results compared field by field.", results_checked);
        if (mismatch_count == 0 && pending_drive_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dmsh_pkg.sv
rtl/core/dmsh_if.sv
rtl/core/dmsh_step.sv
rtl/core/dmsh_slew.sv
rtl/core/dmsh_level.sv
rtl/core/dual_motor_slew_limited_hbridge_drive_top.sv
rtl/core/dmsh_chk.sv
bench/tb_dual_motor_slew_limited_hbridge_drive_top.sv
